### sv/fbb3_pkg.sv
// fbb3_pkg: types and constants of the 3x3 box blur core
// payload structs, control state enum, reciprocal table for the window divisor
// no dependencies
package fbb3_pkg;

  // fixed field widths
  localparam int unsigned DATA_W   = 16;
  localparam int unsigned POS_W    = 10;
  localparam int unsigned CFG_W    = 11;
  localparam int unsigned APB_AW   = 3;
  localparam int unsigned APB_DW   = 32;

  // register map, indexed by paddr[2]
  localparam logic REG_IMAGE_SIZE = 1'b0;
  localparam logic [CFG_W-1:0] SIZE_RESET = 11'd32;

  // reciprocal multiply: floor(x / d) == (x * K) >> RECIP_SHIFT for x < 2^21
  localparam int unsigned RECIP_W     = 25;
  localparam int unsigned RECIP_SHIFT = 24;
  localparam logic [RECIP_W-1:0] RECIP_1 = 25'd16777216;
  localparam logic [RECIP_W-1:0] RECIP_2 = 25'd8388608;
  localparam logic [RECIP_W-1:0] RECIP_3 = 25'd5592406;
  localparam logic [RECIP_W-1:0] RECIP_4 = 25'd4194304;
  localparam logic [RECIP_W-1:0] RECIP_6 = 25'd2796203;
  localparam logic [RECIP_W-1:0] RECIP_9 = 25'd1864136;

  // input item
  typedef struct packed {
    logic [DATA_W-1:0] red_in;
    logic [DATA_W-1:0] green_in;
    logic [DATA_W-1:0] blue_in;
    logic              frame_start;
  } pix_in_t;

  // result item
  typedef struct packed {
    logic [DATA_W-1:0] red_out;
    logic [DATA_W-1:0] green_out;
    logic [DATA_W-1:0] blue_out;
    logic [POS_W-1:0]  out_row;
    logic [POS_W-1:0]  out_col;
    logic              frame_end;
  } pix_out_t;

  // per-item sequence
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SUM,
    ST_MUL
  } state_e;

  // reciprocal for a window of rows x cols pixels (each 1..3)
  function automatic logic [RECIP_W-1:0] div_recip(logic [1:0] rows, logic [1:0] cols);
    logic [RECIP_W-1:0] k;
    unique case ({rows, cols})
      4'b0101:         k = RECIP_1;
      4'b0110, 4'b1001: k = RECIP_2;
      4'b0111, 4'b1101: k = RECIP_3;
      4'b1010:         k = RECIP_4;
      4'b1011, 4'b1110: k = RECIP_6;
      4'b1111:         k = RECIP_9;
      default:         k = RECIP_1;
    endcase
    return k;
  endfunction

endpackage

### sv/forward_box_blur_3x3_core.sv
// forward_box_blur_3x3_core: 3x3 clipped box mean over a square RGB image
// depends on fbb3_pkg (payload structs, state enum, reciprocal table)
//
// Usage:
//   Pixels enter on in_valid_i/in_ready_o in reverse raster order: bottom row
//   first, each row right to left. frame_start marks the bottom-right pixel.
//   Every input item gives one result item on out_valid_o/out_ready_i for the
//   same position: the truncating mean of the in-bounds pixels in rows i..i+2
//   and columns j..j+2, with its row, column and a frame_end flag at (0,0).
//   image_size is written over the APB-style port at address 0 while idle.
// Timing:
//   one item at a time, through the accept / line store read / sum and write
//   back / reciprocal multiply sequence on the single-port line stores; the
//   result is registered at the end of the multiply step.
//   The output register parts the two sides: a new item is accepted while a
//   result waits; a stalled receiver holds the next result in the multiply
//   step and then holds off the input.
// Reset:
//   clears positions, column sums and the output valid flag; image_size returns to 32.
//   Line stores are not cleared; a frame must begin with frame_start.
module forward_box_blur_3x3_core #(
  parameter int unsigned MAX_SIZE     = 1024,
  parameter int unsigned CHANNEL_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // pixel input
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fbb3_pkg::pix_in_t                   in_data_i,
  // result output
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fbb3_pkg::pix_out_t                  out_data_o,
  // configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [fbb3_pkg::APB_AW-1:0]         paddr,
  input  logic [fbb3_pkg::APB_DW-1:0]         pwdata,
  output logic [fbb3_pkg::APB_DW-1:0]         prdata,
  output logic                                pready
);
  import fbb3_pkg::*;

  localparam int unsigned PW  = $clog2(MAX_SIZE);
  localparam int unsigned SW  = PW + 1;
  localparam int unsigned CW  = (SW > CFG_W) ? SW : CFG_W;
  localparam int unsigned LW  = CHANNEL_BITS + 2;
  localparam int unsigned TW  = CHANNEL_BITS + 4;
  localparam int unsigned PXW = 3 * CHANNEL_BITS;
  localparam int unsigned CSW = 3 * LW;
  localparam int unsigned MW  = TW + RECIP_W;

  // configuration register
  logic [CFG_W-1:0] size_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & (paddr[2] == REG_IMAGE_SIZE);
  assign prdata = (paddr[2] == REG_IMAGE_SIZE) ? APB_DW'(size_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_we) begin
      size_q <= pwdata[CFG_W-1:0];
    end
  end

  // effective size, clamped to 1..MAX_SIZE
  logic [CW-1:0] size_ext;
  logic [SW-1:0] size_eff;
  logic [SW-1:0] size_m1;

  always_comb begin
    size_ext = CW'(size_q);
    priority if (size_ext == '0) begin
      size_eff = SW'(1);
    end else if (size_ext > CW'(MAX_SIZE)) begin
      size_eff = SW'(MAX_SIZE);
    end else begin
      size_eff = SW'(size_ext);
    end
    size_m1 = size_eff - SW'(1);
  end

  // control state
  state_e state_q, state_d;
  logic   out_valid_q;
  logic   in_acc, rd_en, sum_en, mul_go;

  assign in_acc = in_valid_i & in_ready_o;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: if (in_valid_i) state_d = ST_READ;
      ST_READ: state_d = ST_SUM;
      ST_SUM:  state_d = ST_MUL;
      ST_MUL:  if (!out_valid_q || out_ready_i) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_ready_o = 1'b0;
    rd_en      = 1'b0;
    sum_en     = 1'b0;
    mul_go     = 1'b0;
    unique case (state_q)
      ST_IDLE: in_ready_o = 1'b1;
      ST_READ: rd_en      = 1'b1;
      ST_SUM:  sum_en     = 1'b1;
      ST_MUL:  mul_go     = !out_valid_q || out_ready_i;
      default: in_ready_o = 1'b0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // position of the arriving pixel
  logic [PW-1:0] row_q, col_q;
  logic [PW-1:0] i_d, j_d;
  logic [PW-1:0] i_q, j_q;
  logic [PXW-1:0] pix_q;

  always_comb begin
    if (in_data_i.frame_start || ({1'b0, row_q} >= size_eff)) begin
      i_d = size_m1[PW-1:0];
    end else begin
      i_d = row_q;
    end
    if (in_data_i.frame_start || ({1'b0, col_q} >= size_eff)) begin
      j_d = size_m1[PW-1:0];
    end else begin
      j_d = col_q;
    end
  end

  // capture item on accept
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      i_q   <= i_d;
      j_q   <= j_d;
      pix_q <= {in_data_i.blue_in[CHANNEL_BITS-1:0],
                in_data_i.green_in[CHANNEL_BITS-1:0],
                in_data_i.red_in[CHANNEL_BITS-1:0]};
    end
  end

  // line stores: row below and two rows below, read then written back at j
  logic [PXW-1:0] line_one [MAX_SIZE];
  logic [PXW-1:0] line_two [MAX_SIZE];
  logic [PXW-1:0] rd_one_q, rd_two_q;

  always_ff @(posedge clk_i) begin
    if (sum_en) begin
      line_one[j_q] <= pix_q;
    end
    if (rd_en) begin
      rd_one_q <= line_one[j_q];
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en) begin
      line_two[j_q] <= rd_one_q;
    end
    if (rd_en) begin
      rd_two_q <= line_two[j_q];
    end
  end

  // window bounds
  logic [SW-1:0] i_ext, j_ext;
  logic          has_b1, has_b2, has_r1, has_r2;
  logic [1:0]    rows, cols;

  always_comb begin
    i_ext  = SW'(i_q);
    j_ext  = SW'(j_q);
    has_b1 = (i_ext + SW'(1)) < size_eff;
    has_b2 = (i_ext + SW'(2)) < size_eff;
    has_r1 = (j_ext + SW'(1)) < size_eff;
    has_r2 = (j_ext + SW'(2)) < size_eff;
    rows   = 2'd1 + {1'b0, has_b1} + {1'b0, has_b2};
    cols   = 2'd1 + {1'b0, has_r1} + {1'b0, has_r2};
  end

  // column sum of this column and window totals per channel
  logic [CSW-1:0] col1_q, col2_q;
  logic [CSW-1:0] colsum;
  logic [TW-1:0]  total [3];
  logic [TW-1:0]  total_q [3];
  logic [RECIP_W-1:0] k_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      logic [LW-1:0] cs;
      logic [TW-1:0] t;
      cs = LW'(pix_q[c*CHANNEL_BITS +: CHANNEL_BITS]);
      if (has_b1) cs = cs + LW'(rd_one_q[c*CHANNEL_BITS +: CHANNEL_BITS]);
      if (has_b2) cs = cs + LW'(rd_two_q[c*CHANNEL_BITS +: CHANNEL_BITS]);
      colsum[c*LW +: LW] = cs;
      t = TW'(cs);
      if (has_r1) t = t + TW'(col1_q[c*LW +: LW]);
      if (has_r2) t = t + TW'(col2_q[c*LW +: LW]);
      total[c] = t;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_en) begin
      for (int c = 0; c < 3; c++) begin
        total_q[c] <= total[c];
      end
      k_q <= div_recip(rows, cols);
    end
  end

  // column sums and position advance
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col1_q <= '0;
      col2_q <= '0;
      row_q  <= '0;
      col_q  <= '0;
    end else if (sum_en) begin
      col2_q <= col1_q;
      col1_q <= colsum;
      if (j_q != '0) begin
        col_q <= j_q - PW'(1);
        row_q <= i_q;
      end else begin
        col_q <= size_m1[PW-1:0];
        row_q <= (i_q != '0) ? (i_q - PW'(1)) : size_m1[PW-1:0];
      end
    end
  end

  // reciprocal multiply into the output register
  logic [MW-1:0]           prod [3];
  logic [CHANNEL_BITS-1:0] quot [3];
  pix_out_t                out_q;

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod[c] = MW'(total_q[c]) * MW'(k_q);
      quot[c] = prod[c][RECIP_SHIFT +: CHANNEL_BITS];
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_go) begin
      out_q.red_out   <= DATA_W'(quot[0]);
      out_q.green_out <= DATA_W'(quot[1]);
      out_q.blue_out  <= DATA_W'(quot[2]);
      out_q.out_row   <= POS_W'(i_q);
      out_q.out_col   <= POS_W'(j_q);
      out_q.frame_end <= (i_q == '0) && (j_q == '0);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mul_go) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
